// ===== rtl/sra_pkg.sv =====
// Shared types, constants and helpers for the signed radix to ASCII unit.
// No dependencies; imported by every module of the block except sra_ram.
package sra_pkg;

    // default parameter values
    localparam int DEF_VALUE_BITS  = 32;
    localparam int DEF_DIGIT_SLOTS = 32;

    // quotient bits resolved per division cycle
    localparam int DIV_STEP = 8;

    // field widths
    localparam int RADIX_BITS    = 5;
    localparam int DIGIT_BITS    = 4;
    localparam int CHAR_BITS     = 7;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    // register map and reset values
    localparam logic [APB_ADDR_BITS-1:0] ADDR_RADIX  = 3'd0;
    localparam logic [RADIX_BITS-1:0]    RADIX_RESET = 5'd10;
    localparam logic [RADIX_BITS-1:0]    RADIX_MIN   = 5'd2;
    localparam logic [RADIX_BITS-1:0]    RADIX_MAX   = 5'd16;

    // character codes
    localparam logic [CHAR_BITS-1:0] MINUS_CHAR  = 7'h2D;
    localparam logic [CHAR_BITS-1:0] ZERO_CHAR   = 7'h30;
    localparam logic [CHAR_BITS-1:0] NINE_CHAR   = 7'h39;
    localparam logic [CHAR_BITS-1:0] UPPER_A     = 7'h41;
    localparam logic [CHAR_BITS-1:0] UPPER_F     = 7'h46;
    localparam logic [DIGIT_BITS-1:0] DIGIT_TEN  = 4'd10;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // capture a new value
        logic div;        // run the divider on the current digit
        logic fin;        // last division cycle of a digit: store it
        logic emit_sign;  // put the minus sign in the output register
        logic rd;         // read the digit store at the current index
        logic emit_char;  // put the read digit in the output register
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic quot_zero;   // quotient of this digit is zero
        logic count_full;  // this digit fills the store
        logic neg;         // value is negative
        logic idx_zero;    // emitting the least significant digit
        logic out_free;    // output register can take a character
    } t_stat;

    // digit value to ASCII, 0-9 then upper-case A-F
    function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
        logic [CHAR_BITS-1:0] ext;
        ext = {{(CHAR_BITS-DIGIT_BITS){1'b0}}, d};
        if (d < DIGIT_TEN)
            digit_char = ZERO_CHAR + ext;
        else
            digit_char = UPPER_A + ext - {{(CHAR_BITS-DIGIT_BITS){1'b0}}, DIGIT_TEN};
    endfunction

endpackage

// ===== rtl/sra_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sra_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we)
            r_mem[i_waddr] <= i_wdata;
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re)
            r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sra_ctrl.sv =====
// Sequencer of the radix converter: accept, divide digit by digit, emit text.
// Depends on sra_pkg for the command and status structs.
module sra_ctrl
    import sra_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_value_valid,
    output logic  o_value_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam int MAG_BITS  = VALUE_BITS + 1;
    localparam int STEPS     = (MAG_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int STEP_BITS = $clog2(STEPS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_SIGN = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]           r_state, n_state;
    logic [STEP_BITS-1:0] r_step,  n_step;
    logic                 last_step;

    assign last_step     = (r_step == STEP_BITS'(STEPS - 1));
    assign o_value_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_value_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                o_cmd.fin = last_step;
                n_step    = last_step ? '0 : r_step + 1'b1;
                if (last_step && (i_stat.quot_zero || i_stat.count_full))
                    n_state = i_stat.neg ? S_SIGN : S_RD;
            end
            S_SIGN: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_char = 1'b1;
                    n_state         = i_stat.idx_zero ? S_IDLE : S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

// ===== rtl/sra_dpath.sv =====
// Datapath of the radix converter: magnitude, shift-subtract divider,
// digit store, and the output register. Depends on sra_pkg and sra_ram.
module sra_dpath
    import sra_pkg::*;
#(
    parameter int VALUE_BITS  = DEF_VALUE_BITS,
    parameter int DIGIT_SLOTS = DEF_DIGIT_SLOTS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic signed [VALUE_BITS-1:0] i_value,
    input  logic [RADIX_BITS-1:0]        i_radix,
    input  t_cmd                         i_cmd,
    output t_stat                        o_stat,
    output logic [CHAR_BITS-1:0]         o_character,
    output logic                         o_last_char,
    output logic                         o_char_valid,
    input  logic                         i_char_ready
);

    localparam int MAG_BITS  = VALUE_BITS + 1;
    localparam int PAD_BITS  = ((MAG_BITS + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
    localparam int CNT_BITS  = $clog2(DIGIT_SLOTS + 1);
    localparam int ADDR_BITS = $clog2(DIGIT_SLOTS);

    logic [PAD_BITS-1:0]   r_work;
    logic [DIGIT_BITS-1:0] r_rem;
    logic [CNT_BITS-1:0]   r_count;
    logic [ADDR_BITS-1:0]  r_idx;
    logic                  r_neg;
    logic                  r_out_valid;
    logic [CHAR_BITS-1:0]  r_out_char;
    logic                  r_out_last;

    logic [MAG_BITS-1:0]   c_sext;
    logic [MAG_BITS-1:0]   c_mag;
    logic [RADIX_BITS-1:0] c_base;
    logic [RADIX_BITS-1:0] c_rem;
    logic [PAD_BITS-1:0]   c_work;
    logic [DIGIT_BITS-1:0] rd_digit;
    logic                  out_free;

    // magnitude, one bit wider than the value
    assign c_sext = {i_value[VALUE_BITS-1], i_value};
    assign c_mag  = i_value[VALUE_BITS-1] ? (~c_sext + 1'b1) : c_sext;

    // saturate the radix to 2..16
    always_comb begin
        if (i_radix < RADIX_MIN)
            c_base = RADIX_MIN;
        else if (i_radix > RADIX_MAX)
            c_base = RADIX_MAX;
        else
            c_base = i_radix;
    end

    // restoring division, DIV_STEP quotient bits per cycle
    always_comb begin
        c_rem  = {1'b0, r_rem};
        c_work = r_work;
        for (int k = 0; k < DIV_STEP; k++) begin
            c_rem  = {c_rem[DIGIT_BITS-1:0], c_work[PAD_BITS-1]};
            c_work = {c_work[PAD_BITS-2:0], 1'b0};
            if (c_rem >= c_base) begin
                c_rem     = c_rem - c_base;
                c_work[0] = 1'b1;
            end
        end
    end

    // division state and digit bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work  <= '0;
            r_rem   <= '0;
            r_count <= '0;
            r_idx   <= '0;
            r_neg   <= 1'b0;
        end else if (i_cmd.load) begin
            r_work  <= PAD_BITS'(c_mag);
            r_rem   <= '0;
            r_count <= '0;
            r_neg   <= i_value[VALUE_BITS-1];
        end else if (i_cmd.div) begin
            r_work <= c_work;
            if (i_cmd.fin) begin
                r_rem   <= '0;
                r_count <= r_count + 1'b1;
                r_idx   <= r_count[ADDR_BITS-1:0];
            end else begin
                r_rem <= c_rem[DIGIT_BITS-1:0];
            end
        end else if (i_cmd.emit_char) begin
            r_idx <= r_idx - 1'b1;
        end
    end

    // digit store, least significant digit at address 0
    sra_ram #(
        .WIDTH (DIGIT_BITS),
        .DEPTH (DIGIT_SLOTS)
    ) u_digits (
        .i_clk   (i_clk),
        .i_we    (i_cmd.fin),
        .i_waddr (r_count[ADDR_BITS-1:0]),
        .i_wdata (c_rem[DIGIT_BITS-1:0]),
        .i_re    (i_cmd.rd),
        .i_raddr (r_idx),
        .o_rdata (rd_digit)
    );

    // output register
    assign out_free = !r_out_valid || i_char_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (i_cmd.emit_sign || i_cmd.emit_char)
            r_out_valid <= 1'b1;
        else if (i_char_ready)
            r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            r_out_char <= MINUS_CHAR;
            r_out_last <= 1'b0;
        end else if (i_cmd.emit_char) begin
            r_out_char <= digit_char(rd_digit);
            r_out_last <= (r_idx == '0);
        end
    end

    // status to the controller
    assign o_stat.quot_zero  = (c_work == '0);
    assign o_stat.count_full = (r_count == CNT_BITS'(DIGIT_SLOTS - 1));
    assign o_stat.neg        = r_neg;
    assign o_stat.idx_zero   = (r_idx == '0);
    assign o_stat.out_free   = out_free;

    assign o_character  = r_out_char;
    assign o_last_char  = r_out_last;
    assign o_char_valid = r_out_valid;

endmodule

// ===== rtl/signed_radix_to_ascii_unit.sv =====
// Signed integer to ASCII text in a radix of 2 to 16, one character per transaction.
// Sequence: accept the value, divide digit by digit (8 quotient bits per division cycle),
// then put out a minus sign for a negative value and each digit character in turn.
// Throughput: one value at a time; the next value is taken while the last character
// still waits in the output register.
// Reset (synchronous, active low): idle, radix 10, no character pending.
module signed_radix_to_ascii_unit
    import sra_pkg::*;
#(
    parameter int VALUE_BITS  = DEF_VALUE_BITS,
    parameter int DIGIT_SLOTS = DEF_DIGIT_SLOTS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // APB configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_ADDR_BITS-1:0]     paddr,
    input  logic [APB_DATA_BITS-1:0]     pwdata,
    output logic [APB_DATA_BITS-1:0]     prdata,
    output logic                         pready,
    // input channel
    input  logic                         i_value_valid,
    output logic                         o_value_ready,
    input  logic signed [VALUE_BITS-1:0] i_value,
    // output channel
    output logic                         o_char_valid,
    input  logic                         i_char_ready,
    output logic [CHAR_BITS-1:0]         o_character,
    output logic                         o_last_char
);

    logic [RADIX_BITS-1:0] r_radix;
    t_cmd                  cmd;
    t_stat                 stat;

    // radix register
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_radix <= RADIX_RESET;
        else if (psel && penable && pwrite && pready && (paddr == ADDR_RADIX))
            r_radix <= pwdata[RADIX_BITS-1:0];
    end

    assign prdata = (paddr == ADDR_RADIX) ? APB_DATA_BITS'(r_radix) : '0;

    // controller
    sra_ctrl #(
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_value_valid (i_value_valid),
        .o_value_ready (o_value_ready),
        .i_stat        (stat),
        .o_cmd         (cmd)
    );

    // datapath
    sra_dpath #(
        .VALUE_BITS  (VALUE_BITS),
        .DIGIT_SLOTS (DIGIT_SLOTS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_value      (i_value),
        .i_radix      (r_radix),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_character  (o_character),
        .o_last_char  (o_last_char),
        .o_char_valid (o_char_valid),
        .i_char_ready (i_char_ready)
    );

    // a value is taken only once per conversion
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_value_valid && o_value_ready |=> !o_value_ready)
        else $error("input accepted on consecutive cycles");

    // the text never ends on the sign
    a_last_not_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_char_valid && o_last_char |-> o_character != MINUS_CHAR)
        else $error("minus sign flagged as last character");

    // only sign, decimal digits and A-F leave the block
    a_legal_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_char_valid |-> (o_character == MINUS_CHAR)
            || (o_character >= ZERO_CHAR && o_character <= NINE_CHAR)
            || (o_character >= UPPER_A && o_character <= UPPER_F))
        else $error("illegal character code");

endmodule

// ===== test/sra_text_checker.sv =====
// Checker for the signed radix to ASCII unit: predicts the text of each accepted value.
// Watches the configuration port and both channels; depends on sra_pkg only.
`timescale 1ns / 100ps

module sra_text_checker
    import sra_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration port, observed only
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_BITS-1:0]  paddr,
    input  logic [APB_DATA_BITS-1:0]  pwdata,
    input  logic                      pready,
    // value channel
    input  logic                      i_value_valid,
    input  logic                      i_value_ready,
    input  logic signed [DEF_VALUE_BITS-1:0] i_value,
    // character channel
    input  logic                      i_char_valid,
    input  logic                      i_char_ready,
    input  logic [CHAR_BITS-1:0]      i_character,
    input  logic                      i_last_char,
    // status to the testbench top
    output int                        o_mismatches,
    output int                        o_outstanding
);

    localparam int VALUE_W     = DEF_VALUE_BITS;
    localparam int DIGIT_SLOTS = DEF_DIGIT_SLOTS;

    // digit glyphs, highest byte is digit zero
    localparam logic [8*16-1:0] GLYPHS = "0123456789ABCDEF";

    typedef struct packed {
        logic [CHAR_BITS-1:0] code;
        logic                 last;
    } t_glyph;

    t_glyph                pending_text[$];
    t_glyph                head;
    logic [RADIX_BITS-1:0] radix_q;

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    // queue the characters that one value should produce
    function automatic void spell_value(input logic [VALUE_W-1:0] value,
                                        input logic [RADIX_BITS-1:0] base_reg);
        logic [RADIX_BITS-1:0] eff;
        logic [VALUE_W:0]      base;
        logic [VALUE_W:0]      mag;
        logic [DIGIT_BITS-1:0] digits [DIGIT_SLOTS];
        int                    ndig;
        t_glyph                entry;
        // out-of-range radix saturates to the nearest legal base
        if (base_reg < RADIX_MIN)
            eff = RADIX_MIN;
        else if (base_reg > RADIX_MAX)
            eff = RADIX_MAX;
        else
            eff = base_reg;
        base = {{(VALUE_W+1-RADIX_BITS){1'b0}}, eff};
        // magnitude is one bit wider so the most negative value survives
        if (value[VALUE_W-1]) begin
            mag = {1'b1, {VALUE_W{1'b0}}} - {1'b0, value};
            entry.code = MINUS_CHAR;
            entry.last = 1'b0;
            pending_text.push_back(entry);
        end else begin
            mag = {1'b0, value};
        end
        // remainders come out least significant first
        ndig = 0;
        do begin
            digits[ndig] = DIGIT_BITS'(mag % base);
            mag = mag / base;
            ndig++;
        end while (mag != 0 && ndig < DIGIT_SLOTS);
        for (int i = ndig - 1; i >= 0; i--) begin
            entry.code = GLYPHS[8*(15-int'(digits[i])) +: CHAR_BITS];
            entry.last = (i == 0);
            pending_text.push_back(entry);
        end
    endfunction

    task automatic flag_error(input string detail);
        o_mismatches++;
        if (o_mismatches <= 10)
            $display("%0t sra_text_checker: %s", $time, detail);
    endtask

    // sample every transaction at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            radix_q = RADIX_RESET;
            pending_text.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_RADIX)
                radix_q = pwdata[RADIX_BITS-1:0];
            // check the character before queuing any new value's text
            if (i_char_valid && i_char_ready) begin
                if (pending_text.size() == 0) begin
                    flag_error($sformatf("unexpected character 0x%02h last %0b",
                                         i_character, i_last_char));
                end else begin
                    head = pending_text.pop_front();
                    if (head.code !== i_character || head.last !== i_last_char)
                        flag_error($sformatf("character 0x%02h last %0b, wanted 0x%02h last %0b",
                                             i_character, i_last_char, head.code, head.last));
                end
            end
            if (i_value_valid && i_value_ready)
                spell_value(i_value, radix_q);
        end
        o_outstanding = pending_text.size();
    end

endmodule

// ===== test/signed_radix_to_ascii_unit_tb.sv =====
// Testbench top for signed_radix_to_ascii_unit: clock, reset, stimulus and verdict.
// Depends on sra_pkg, the unit itself and sra_text_checker.
`timescale 1ns / 100ps

module signed_radix_to_ascii_unit_tb;
    import sra_pkg::*;

    localparam int IDLE_LIMIT      = 2000;
    localparam int ITEMS_PER_PHASE = 30;
    localparam int PHASES          = 10;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [APB_ADDR_BITS-1:0]   paddr;
    logic [APB_DATA_BITS-1:0]   pwdata;
    logic [APB_DATA_BITS-1:0]   prdata;
    logic                       pready;
    logic                       i_value_valid;
    logic                       o_value_ready;
    logic signed [31:0]         i_value;
    logic                       o_char_valid;
    logic                       i_char_ready;
    logic [CHAR_BITS-1:0]       o_character;
    logic                       o_last_char;

    int                         mismatches;
    int                         outstanding;
    int                         idle_cycles;
    logic                       no_gaps;
    logic [RADIX_BITS-1:0]      cur_radix;

    signed_radix_to_ascii_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_value_valid (i_value_valid),
        .o_value_ready (o_value_ready),
        .i_value       (i_value),
        .o_char_valid  (o_char_valid),
        .i_char_ready  (i_char_ready),
        .o_character   (o_character),
        .o_last_char   (o_last_char)
    );

    sra_text_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .i_value_valid (i_value_valid),
        .i_value_ready (o_value_ready),
        .i_value       (i_value),
        .i_char_valid  (o_char_valid),
        .i_char_ready  (i_char_ready),
        .i_character   (o_character),
        .i_last_char   (o_last_char),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // 4 ns clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // watchdog: cycles without any transaction
    initial idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_value_valid && o_value_ready) || (o_char_valid && i_char_ready) ||
            (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("signed_radix_to_ascii_unit_tb: done, errors");
                $finish;
            end
        end
    end

    // character sink with random stalls
    initial begin
        int stall;
        i_char_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                i_char_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_char_ready <= 1'b1;
            do @(posedge i_clk); while (!o_char_valid);
            @(negedge i_clk);
        end
    end

    // one value transaction; entered and left at a falling edge
    task automatic send_value(input logic [31:0] v);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_value_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_value_valid <= 1'b1;
        i_value       <= v;
        do @(posedge i_clk); while (!o_value_ready);
        @(negedge i_clk);
    endtask

    // radix write once the unit has drained
    task automatic set_radix(input logic [RADIX_BITS-1:0] r);
        i_value_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (4) @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_RADIX;
        pwdata  <= APB_DATA_BITS'(r);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_radix = r;
    endtask

    // random value: wide random, small, extremes, or near a power of the radix
    function automatic logic [31:0] pick_value();
        logic [63:0] p;
        logic [63:0] eff;
        logic [31:0] v;
        int          kind;
        kind = $urandom_range(0, 9);
        eff  = (cur_radix < RADIX_MIN) ? 64'(RADIX_MIN) :
               (cur_radix > RADIX_MAX) ? 64'(RADIX_MAX) : 64'(cur_radix);
        if (kind <= 3) begin
            v = $urandom;
        end else if (kind <= 5) begin
            v = 32'($urandom_range(0, 40));
            if ($urandom_range(0, 1) == 1)
                v = -v;
        end else if (kind == 6) begin
            case ($urandom_range(0, 5))
                0: v = 32'h8000_0000;
                1: v = 32'h8000_0001;
                2: v = 32'h7FFF_FFFF;
                3: v = 32'h7FFF_FFFE;
                4: v = 32'h0000_0000;
                default: v = 32'hFFFF_FFFF;
            endcase
        end else begin
            p = 64'd1;
            repeat ($urandom_range(1, 31)) begin
                if (p * eff <= 64'h8000_0000)
                    p = p * eff;
            end
            v = p[31:0] - 32'd1 + 32'($urandom_range(0, 2));
            if ($urandom_range(0, 1) == 1)
                v = -v;
        end
        return v;
    endfunction

    initial begin
        logic [RADIX_BITS-1:0] phase_radix [PHASES];
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_value_valid = 1'b0;
        i_value       = '0;
        no_gaps       = 1'b0;
        cur_radix     = RADIX_RESET;
        i_rst_n       = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: decimal from reset, zero, signs and both extremes
        send_value(32'd0);
        send_value(32'd1);
        send_value(-32'sd1);
        send_value(32'd9);
        send_value(32'd10);
        send_value(-32'sd10);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(-32'sd987654321);
        // hexadecimal, letter digits
        set_radix(5'd16);
        send_value(32'd15);
        send_value(32'hFFFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        send_value(32'h00AB_CDEF);
        // binary: most negative value gives the longest text
        set_radix(5'd2);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        send_value(32'd1);
        send_value(-32'sd2);
        // radix below two saturates to binary
        set_radix(5'd0);
        send_value(32'd5);
        send_value(-32'sd5);
        set_radix(5'd1);
        send_value(32'd6);
        // radix above sixteen saturates to hexadecimal
        set_radix(5'd31);
        send_value(32'd255);
        send_value(-32'sd256);
        set_radix(5'd17);
        send_value(32'h8000_0001);
        set_radix(5'd3);
        send_value(32'h8000_0000);
        set_radix(5'd7);
        send_value(32'd48);

        // random phases, each under its own radix
        phase_radix = '{5'd2, 5'd16, 5'd10, 5'd0, 5'd31, 5'd5, 5'd8, 5'd1, 5'd17,
                        RADIX_BITS'($urandom_range(0, 31))};
        for (int ph = 0; ph < PHASES; ph++) begin
            set_radix(phase_radix[ph]);
            no_gaps = (ph == 3 || ph == 7);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // now and then hold off until the unit has drained
                if ($urandom_range(0, 19) == 0) begin
                    i_value_valid <= 1'b0;
                    wait (outstanding == 0);
                    @(negedge i_clk);
                end
                send_value(pick_value());
            end
        end
        no_gaps = 1'b0;

        i_value_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (80) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("signed_radix_to_ascii_unit_tb: done, clean");
        end else begin
            $display("signed_radix_to_ascii_unit_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sra_pkg.sv
rtl/sra_ram.sv
rtl/sra_ctrl.sv
rtl/sra_dpath.sv
rtl/signed_radix_to_ascii_unit.sv
test/sra_text_checker.sv
test/signed_radix_to_ascii_unit_tb.sv
